### hdl/sfa_pkg.sv
// shared types, codes and constants of the stack frame allocator
package sfa_pkg;

   localparam int unsigned MAX_FRAMES_DEFAULT   = 16;
   localparam int unsigned HEADER_BYTES_DEFAULT = 8;
   localparam int unsigned HDR_ALIGN            = 8;
   localparam int unsigned POOL_PAGE_BYTES      = 4096;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned BYTES_W = 21;
   localparam int unsigned ALIGN_W = 4;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned STAT_W  = 2;
   // wide enough for an aligned block end past the top of the address space
   localparam int unsigned WIDE_W  = ADDR_W + 2;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC       = 2'd0,
      FUNC_ALLOC_ALIGN = 2'd1,
      FUNC_FREE        = 2'd2,
      FUNC_POP         = 2'd3
   } sfa_func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } sfa_status_type;

   typedef enum logic {
      REG_POOL_BASE  = 1'b0,
      REG_POOL_BYTES = 1'b1
   } sfa_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HDR,
      ST_BLK,
      ST_COMMIT
   } sfa_state_type;

   // shift control shared by every cell of the header stack
   typedef struct packed {
      logic push;
      logic pop;
   } sfa_shift_type;

endpackage

### hdl/sfa_cell.sv
// one cell of the frame header stack, shifts down on push and up on pop
module sfa_cell (
   input  logic                        clock,
   input  sfa_pkg::sfa_shift_type      shift,
   input  logic [sfa_pkg::ADDR_W-1:0]  from_above,
   input  logic [sfa_pkg::ADDR_W-1:0]  from_below,
   output logic [sfa_pkg::ADDR_W-1:0]  header
);
   import sfa_pkg::*;

   logic [ADDR_W-1:0] header_ff;
   logic [ADDR_W-1:0] header_in;

   always_comb begin
      header_in = header_ff;
      if (shift.push) begin
         header_in = from_above;
      end else if (shift.pop) begin
         header_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
   end

   assign header = header_ff;

endmodule

### hdl/stack_frame_allocator.sv
// top level of the stack frame allocator: control, address path and header cell chain
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------------
//  req      | in        | req_tvalid/req_tready | tuser func, tdata bytes + align_log2
//  rsp      | out       | rsp_tvalid/rsp_tready | tuser status, tdata block/count/free addr
//  csr      | in        | csr_we                | csr_index, csr_wdata (no read-back)
//
//  every request passes through the steps accept, header round-up, block alignment and commit
//  the three-step add chain of an alloc (round to 8, add header, align) is split over the header and block steps
//  one request is worked at a time; the next is taken once the commit has happened
//  a finished result sits in the output register while the next request is accepted
//  commit stalls only while the output register still holds an untaken result
//  reset is synchronous; base, length, next-free and depth clear, no clearing pass
module stack_frame_allocator #(
   parameter int unsigned MAX_FRAMES   = sfa_pkg::MAX_FRAMES_DEFAULT,
   parameter int unsigned HEADER_BYTES = sfa_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [20:0] request_bytes, [24:21] align_log2, rest zero
   input  logic [sfa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] func
   input  logic [sfa_pkg::FUNC_W-1:0]      req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] block_address, [36:32] frame_count, [68:37] free_address, rest zero
   output logic [sfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [sfa_pkg::STAT_W-1:0]      rsp_tuser,
   // configuration write port
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [sfa_pkg::ADDR_W-1:0]      csr_wdata
);
   import sfa_pkg::*;

   localparam int unsigned DEPTH_W = $clog2(MAX_FRAMES + 1);
   localparam int unsigned CNT_W   = (DEPTH_W > COUNT_W) ? DEPTH_W : COUNT_W;
   localparam logic [WIDE_W-1:0] DEF_MASK = WIDE_W'(HDR_ALIGN - 1);

   // control and captured request
   sfa_state_type       state_ff, state_in;
   sfa_func_type        func_ff, func_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [ALIGN_W-1:0]  alog_ff, alog_in;

   // address path
   logic [WIDE_W-1:0]   hdr_ff, hdr_in;        // header address, rounded to default align
   logic [ADDR_W:0]     lim_ff, lim_in;        // pool end, clamped to 2^32
   logic [WIDE_W-1:0]   blk_ff, blk_in;        // block address

   // allocator state
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic [BYTES_W-1:0]  pool_bytes_ff, pool_bytes_in;
   logic [ADDR_W-1:0]   nf_ff, nf_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;
   logic [ADDR_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [ADDR_W-1:0]   rsp_free_ff, rsp_free_in;

   // header cell chain
   sfa_shift_type       shift;
   logic [ADDR_W-1:0]   cell_q [MAX_FRAMES];

   // combinational helpers
   logic [WIDE_W-1:0]   align_mask;
   logic [WIDE_W-1:0]   blk_base;
   logic [WIDE_W-1:0]   blk_end;
   logic [ADDR_W:0]     pool_sum;
   logic [ADDR_W-1:0]   used;
   logic                out_free;
   logic [CNT_W-1:0]    depth_ext;

   // a row of identical cells; cell 0 holds the top frame header
   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic [ADDR_W-1:0] above;
      logic [ADDR_W-1:0] below;
      if (i == 0) begin : g_head
         assign above = hdr_ff[ADDR_W-1:0];
      end else begin : g_mid
         assign above = cell_q[i-1];
      end
      if (i == MAX_FRAMES - 1) begin : g_tail
         assign below = cell_q[i];
      end else begin : g_body
         assign below = cell_q[i+1];
      end
      sfa_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .header     (cell_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      bytes_in      = bytes_ff;
      alog_in       = alog_ff;
      hdr_in        = hdr_ff;
      lim_in        = lim_ff;
      blk_in        = blk_ff;
      base_in       = base_ff;
      pool_bytes_in = pool_bytes_ff;
      nf_in         = nf_ff;
      depth_in      = depth_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_stat_in   = rsp_stat_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_free_in   = rsp_free_ff;
      shift         = '0;
      req_tready    = 1'b0;
      depth_ext     = '0;

      out_free   = !rsp_valid_ff || rsp_tready;
      align_mask = (WIDE_W'(1) << alog_ff) - WIDE_W'(1);
      blk_base   = hdr_ff + WIDE_W'(HEADER_BYTES);
      blk_end    = blk_ff + WIDE_W'(bytes_ff);
      pool_sum   = {1'b0, base_ff} + (ADDR_W+1)'(pool_bytes_ff);
      used       = nf_ff - base_ff;

      // taken response leaves the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = sfa_func_type'(req_tuser);
               bytes_in = req_tdata[BYTES_W-1:0];
               alog_in  = req_tdata[BYTES_W +: ALIGN_W];
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            // header goes at next-free rounded up to the default alignment
            hdr_in = (WIDE_W'(nf_ff) + DEF_MASK) & ~DEF_MASK;
            // pool end saturates at the top of the address space
            lim_in = pool_sum[ADDR_W] ? {1'b1, {ADDR_W{1'b0}}} : pool_sum;
            state_in = ST_BLK;
         end
         ST_BLK: begin
            if (func_ff == FUNC_ALLOC_ALIGN) begin
               blk_in = (blk_base + align_mask) & ~align_mask;
            end else begin
               blk_in = blk_base;
            end
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               rsp_stat_in  = STATUS_OK;
               rsp_block_in = '0;
               case (func_ff)
                  FUNC_ALLOC, FUNC_ALLOC_ALIGN: begin
                     if (depth_ff >= DEPTH_W'(MAX_FRAMES)) begin
                        rsp_stat_in = STATUS_FULL;
                     end else if (blk_end >= WIDE_W'(lim_ff)) begin
                        rsp_stat_in = STATUS_NO_SPACE;
                     end else begin
                        shift.push   = 1'b1;
                        depth_in     = depth_ff + DEPTH_W'(1);
                        nf_in        = blk_end[ADDR_W-1:0];
                        rsp_block_in = blk_ff[ADDR_W-1:0];
                     end
                  end
                  FUNC_FREE: begin
                     // release clamps at the pool base
                     if (nf_ff < base_ff || used < ADDR_W'(bytes_ff)) begin
                        nf_in = base_ff;
                     end else begin
                        nf_in = nf_ff - ADDR_W'(bytes_ff);
                     end
                  end
                  FUNC_POP: begin
                     if (depth_ff == '0) begin
                        rsp_stat_in = STATUS_EMPTY;
                     end else begin
                        shift.pop = 1'b1;
                        depth_in  = depth_ff - DEPTH_W'(1);
                        // last frame rewinds to base, otherwise to the popped header
                        nf_in = (depth_ff == DEPTH_W'(1)) ? base_ff : cell_q[0];
                     end
                  end
                  default: begin
                     rsp_stat_in = STATUS_OK;
                  end
               endcase
               depth_ext    = CNT_W'(depth_in);
               rsp_count_in = depth_ext[COUNT_W-1:0];
               rsp_free_in  = nf_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the user must write registers only while no request is in flight; the block does not enforce this
      if (csr_we) begin
         case (sfa_reg_type'(csr_index))
            REG_POOL_BASE: begin
               base_in  = csr_wdata;
               nf_in    = csr_wdata;
               depth_in = '0;
            end
            REG_POOL_BYTES: begin
               pool_bytes_in = csr_wdata[BYTES_W-1:0];
            end
            default: begin
               pool_bytes_in = pool_bytes_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= '0;
         pool_bytes_ff <= '0;
         nf_ff         <= '0;
         depth_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         pool_bytes_ff <= pool_bytes_in;
         nf_ff         <= nf_in;
         depth_ff      <= depth_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      bytes_ff     <= bytes_in;
      alog_ff      <= alog_in;
      hdr_ff       <= hdr_in;
      lim_ff       <= lim_in;
      blk_ff       <= blk_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_block_ff <= rsp_block_in;
      rsp_count_ff <= rsp_count_in;
      rsp_free_ff  <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 2*ADDR_W - COUNT_W)'(0),
                        rsp_free_ff, rsp_count_ff, rsp_block_ff};

   // stack never holds more frames than it has cells
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(MAX_FRAMES))
      else $error("frame depth above stack size");

   // next-free never drops below the pool base
   a_nf_above_base: assert property (@(posedge clock) disable iff (reset)
      nf_ff >= base_ff)
      else $error("next-free below pool base");

   // a failed request never hands out a block address
   a_fail_no_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stat_ff != STATUS_OK) |-> rsp_block_ff == '0)
      else $error("block address on failed request");

   // a blocked commit holds its state until the output register drains
   a_commit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_COMMIT)
      else $error("commit left with output register full");

endmodule

### dv/tb_stack_frame_allocator.sv
// self-checking testbench of the stack frame allocator: directed cases and random traffic against a predictor
`timescale 1ns / 1ps

module tb_stack_frame_allocator;
   import sfa_pkg::*;

   // cycles with no handshake and no register write before the run is given up
   localparam int unsigned QUIET_LIMIT = 1000;
   // least number of random requests per configuration phase, and number of phases
   localparam int unsigned PHASE_REQUESTS = 55;
   localparam int unsigned PHASE_COUNT    = 10;
   localparam int unsigned STACK_IDX_W    = $clog2(MAX_FRAMES_DEFAULT);

   typedef struct {
      sfa_func_type       op;
      logic [BYTES_W-1:0] nbytes;
      logic [ALIGN_W-1:0] alog;
   } alloc_request_type;

   typedef struct {
      sfa_status_type     status;
      logic [ADDR_W-1:0]  block;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  free;
   } alloc_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [20:0] request_bytes, [24:21] align_log2, rest zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [1:0] func
   logic [FUNC_W-1:0]     req_tuser  = FUNC_ALLOC;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] block_address, [36:32] frame_count, [68:37] free_address, rest zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] status
   logic [STAT_W-1:0]     rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = REG_POOL_BASE;
   logic [ADDR_W-1:0]     csr_wdata  = '0;

   // predictor state: pool window, bump pointer and the stack of header addresses
   logic [ADDR_W-1:0]  cfg_base    = '0;
   logic [BYTES_W-1:0] cfg_len     = '0;
   logic [ADDR_W-1:0]  bump_addr   = '0;
   logic [COUNT_W-1:0] stack_depth = '0;
   logic [ADDR_W-1:0]  header_stack [MAX_FRAMES_DEFAULT];

   alloc_request_type pending_requests [$];
   alloc_result_type  expected_results [$];
   int unsigned    requests_queued = 0;
   int unsigned    results_checked = 0;
   int unsigned    error_count     = 0;
   int unsigned    quiet_cycles    = 0;
   int unsigned    req_gap         = 0;
   int unsigned    rsp_hold        = 0;
   bit             req_burst       = 1'b0;
   bit             rsp_burst       = 1'b0;

   stack_frame_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // one request through the allocator; updates the predictor state and returns the result
   function automatic alloc_result_type step_allocator(sfa_func_type op,
                                                       logic [BYTES_W-1:0] nbytes,
                                                       logic [ALIGN_W-1:0] alog);
      alloc_result_type  r;
      logic [WIDE_W-1:0] hdr;
      logic [WIDE_W-1:0] blk;
      logic [WIDE_W-1:0] blk_end;
      logic [WIDE_W-1:0] lim;
      logic [WIDE_W-1:0] mask;
      r.status = STATUS_OK;
      r.block  = '0;
      case (op)
         FUNC_ALLOC, FUNC_ALLOC_ALIGN: begin
            // a full stack is reported ahead of a lack of space
            if (stack_depth >= MAX_FRAMES_DEFAULT) begin
               r.status = STATUS_FULL;
            end else begin
               mask = WIDE_W'(HDR_ALIGN - 1);
               hdr  = WIDE_W'(bump_addr);
               hdr  = (hdr + mask) & ~mask;
               blk  = hdr + WIDE_W'(HEADER_BYTES_DEFAULT);
               if (op == FUNC_ALLOC_ALIGN) begin
                  mask = WIDE_W'(1);
                  mask = (mask << alog) - WIDE_W'(1);
                  blk  = (blk + mask) & ~mask;
               end
               blk_end = blk + WIDE_W'(nbytes);
               // pool end saturates at the top of the 32-bit address space
               lim = WIDE_W'(cfg_base);
               lim = lim + WIDE_W'(cfg_len);
               if (lim > 34'h0_FFFF_FFFF) lim = 34'h1_0000_0000;
               if (blk_end >= lim) begin
                  r.status = STATUS_NO_SPACE;
               end else begin
                  header_stack[stack_depth[STACK_IDX_W-1:0]] = hdr[ADDR_W-1:0];
                  stack_depth = stack_depth + COUNT_W'(1);
                  bump_addr   = blk_end[ADDR_W-1:0];
                  r.block     = blk[ADDR_W-1:0];
               end
            end
         end
         FUNC_FREE: begin
            // release clamps at the pool base
            if (bump_addr < cfg_base || (bump_addr - cfg_base) < ADDR_W'(nbytes))
               bump_addr = cfg_base;
            else
               bump_addr = bump_addr - ADDR_W'(nbytes);
         end
         default: begin
            if (stack_depth == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               // rewind to the popped header, or to the base once the stack is empty
               stack_depth = stack_depth - COUNT_W'(1);
               bump_addr   = (stack_depth == 0) ? cfg_base
                                                : header_stack[stack_depth[STACK_IDX_W-1:0]];
            end
         end
      endcase
      r.count = stack_depth;
      r.free  = bump_addr;
      return r;
   endfunction

   function automatic int unsigned draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   // mostly small sizes relative to the pool, now and then anything the field holds
   function automatic logic [BYTES_W-1:0] draw_request_bytes();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return BYTES_W'($urandom_range(0, 21'h1F_FFFF));
      if (pick == 1) return BYTES_W'($urandom_range(0, cfg_len));
      return BYTES_W'($urandom_range(0, (cfg_len >> 5) + 16));
   endfunction

   function automatic logic [ALIGN_W-1:0] draw_align();
      return ALIGN_W'($urandom_range(0, 15));
   endfunction

   task automatic queue_request(sfa_func_type op, logic [BYTES_W-1:0] nbytes,
                                logic [ALIGN_W-1:0] alog);
      alloc_request_type item;
      item.op     = op;
      item.nbytes = nbytes;
      item.alog   = alog;
      pending_requests.push_back(item);
      requests_queued++;
   endtask

   // register write on an idle block; the predictor takes the new value at once
   task automatic write_register(sfa_reg_type idx, logic [ADDR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_POOL_BASE) begin
         // a new base also resets the bump pointer and empties the stack
         cfg_base    = value;
         bump_addr   = value;
         stack_depth = '0;
      end else begin
         cfg_len = value[BYTES_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_pool(logic [ADDR_W-1:0] base, logic [BYTES_W-1:0] len);
      if ($urandom_range(0, 1)) begin
         write_register(REG_POOL_BASE, base);
         write_register(REG_POOL_BYTES, ADDR_W'(len));
      end else begin
         write_register(REG_POOL_BYTES, ADDR_W'(len));
         write_register(REG_POOL_BASE, base);
      end
   endtask

   task automatic wait_drained();
      while (results_checked < requests_queued) @(posedge clock);
   endtask

   // a run of allocations, with a stray free now and then, unwound by some pops
   task automatic queue_frame_sequence();
      int unsigned n_alloc;
      int unsigned n_pop;
      n_alloc = $urandom_range(1, 20);
      repeat (n_alloc) begin
         if ($urandom_range(0, 7) == 0)
            queue_request(FUNC_FREE, draw_request_bytes(), draw_align());
         queue_request($urandom_range(0, 1) ? FUNC_ALLOC_ALIGN : FUNC_ALLOC,
                       draw_request_bytes(), draw_align());
      end
      n_pop = $urandom_range(0, n_alloc + 2);
      repeat (n_pop) queue_request(FUNC_POP, draw_request_bytes(), draw_align());
   endtask

   // request side: pending queue onto the bus, prediction at each accepted request
   always @(posedge clock) begin : request_driver
      alloc_request_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_results.push_back(step_allocator(sfa_func_type'(req_tuser),
                                                      req_tdata[20:0], req_tdata[24:21]));
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            nxt = pending_requests.pop_front();
            req_tuser  <= nxt.op;
            req_tdata  <= {7'd0, nxt.alog, nxt.nbytes};
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 29) == 0) req_burst = !req_burst;
            req_gap = draw_wait(req_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: random stalls after each result, field by field compare
   always @(posedge clock) begin : response_monitor
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            got.status = sfa_status_type'(rsp_tuser);
            got.block  = rsp_tdata[31:0];
            got.count  = rsp_tdata[36:32];
            got.free   = rsp_tdata[68:37];
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result with no request waiting: status %0d block %h",
                        $time, got.status, got.block);
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status) begin
                  error_count++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               end
               if (got.block != want.block) begin
                  error_count++;
                  $display("%0t: block_address expected %h actual %h",
                           $time, want.block, got.block);
               end
               if (got.count != want.count) begin
                  error_count++;
                  $display("%0t: frame_count expected %0d actual %0d",
                           $time, want.count, got.count);
               end
               if (got.free != want.free) begin
                  error_count++;
                  $display("%0t: free_address expected %h actual %h",
                           $time, want.free, got.free);
               end
            end
            if ($urandom_range(0, 29) == 0) rsp_burst = !rsp_burst;
            rsp_hold = draw_wait(rsp_burst);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // a stretch with no handshake and no register write means the block hung
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_stack_frame_allocator NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset state: zero-length pool, so allocs fail; empty pop; oversized free
      queue_request(FUNC_ALLOC, 21'd0, 4'd0);
      queue_request(FUNC_POP, 21'd0, 4'd0);
      queue_request(FUNC_FREE, 21'h1F_FFFF, 4'hF);
      queue_request(FUNC_ALLOC_ALIGN, 21'd0, 4'd15);
      wait_drained();

      // one page pool: plain and aligned allocs, overflow, clamped free, unwind past empty
      set_pool(32'h0001_0000, 21'h00_1000);
      queue_request(FUNC_ALLOC, 21'd0, 4'd0);
      queue_request(FUNC_ALLOC_ALIGN, 21'd100, 4'd12);
      queue_request(FUNC_ALLOC_ALIGN, 21'd3, 4'd0);
      queue_request(FUNC_ALLOC, 21'h1F_FFFF, 4'd0);
      queue_request(FUNC_ALLOC_ALIGN, 21'd0, 4'd15);
      queue_request(FUNC_FREE, 21'd5, 4'd0);
      queue_request(FUNC_FREE, 21'h1F_FFFF, 4'd0);
      repeat (4) queue_request(FUNC_POP, 21'd0, 4'd0);
      wait_drained();

      // pool at the top of the address space: a block that would end exactly at the saturated end is refused
      set_pool(32'hFFFF_F000, 21'h10_0000);
      queue_request(FUNC_ALLOC, 21'h00_0FF0, 4'd0);
      queue_request(FUNC_ALLOC, 21'd0, 4'd0);
      queue_request(FUNC_FREE, 21'd0, 4'd0);
      queue_request(FUNC_POP, 21'd0, 4'd0);
      wait_drained();

      // random phases, each with its own pool setting
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 6)
            0: set_pool(32'h0000_0000, 21'h1F_FFFF);
            1: set_pool(32'hFFFF_FFFF, BYTES_W'($urandom_range(0, 21'h1F_FFFF)));
            2: set_pool($urandom & 32'hFFFF_F000, BYTES_W'($urandom_range(1, 4) << 12));
            3: set_pool(32'hFFFF_F000 - ($urandom_range(0, 255) << 12), 21'h10_0000);
            4: set_pool($urandom, BYTES_W'($urandom_range(0, 21'h1F_FFFF)));
            default: set_pool($urandom & 32'hFFFF_F000, 21'd0);
         endcase
         phase_start = requests_queued;
         while (requests_queued - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 3) != 0) begin
               queue_frame_sequence();
            end else begin
               // noise: any function with any content
               repeat ($urandom_range(1, 8))
                  queue_request(sfa_func_type'($urandom_range(0, 3)),
                                draw_request_bytes(), draw_align());
            end
         end
         wait_drained();
      end

      // catch any stray result after the last expected one
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("tb_stack_frame_allocator OK");
      else $display("tb_stack_frame_allocator NOT OK");
      $finish;
   end

endmodule

### stack_frame_allocator.f
hdl/sfa_pkg.sv
hdl/sfa_cell.sv
hdl/stack_frame_allocator.sv
dv/tb_stack_frame_allocator.sv
